@@ hw/rtl/ttag_pkg.sv @@
// Shared constants and types for the tensor transpose address generator.
`timescale 1ns / 1ps

package ttag_pkg;

    localparam int VALUE_W     = 32;   // element word
    localparam int NUM_DIMS_W  = 3;    // num_dims register
    localparam int ORDER_W     = 8;    // axis_order register
    localparam int AXIS_SEL_W  = 2;    // one source-axis field of axis_order
    localparam int MAX_AXES    = 4;    // axes addressable through axis_order
    localparam int CFG_INDEX_W = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 8'd228;  // identity order

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_NUM_DIMS   = 3'd0,
        REG_DIM_SIZE_0 = 3'd1,
        REG_DIM_SIZE_1 = 3'd2,
        REG_DIM_SIZE_2 = 3'd3,
        REG_DIM_SIZE_3 = 3'd4,
        REG_AXIS_ORDER = 3'd5
    } t_cfg_reg;

    // Tensor geometry seen by the odometer
    typedef struct packed {
        logic [NUM_DIMS_W-1:0] n_act;       // axes in use, 1..MAX_AXES
        logic [ORDER_W-1:0]    axis_order;  // source axis per output axis
    } t_geom;

endpackage

@@ hw/rtl/ttag_cfg.sv @@
// Configuration registers and the sequential output-stride calculator.
`timescale 1ns / 1ps

module ttag_cfg #(
    parameter int NUM_AXES   = 4,
    parameter int DIM_WIDTH  = 16,
    parameter int ADDR_WIDTH = 32,
    parameter int CFG_WIDTH  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [ttag_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [CFG_WIDTH-1:0]                i_cfg_data,
    output ttag_pkg::t_geom                     o_geom,
    output logic [DIM_WIDTH-1:0]                o_ext_m1 [NUM_AXES],
    output logic [ADDR_WIDTH-1:0]               o_stride [NUM_AXES],
    output logic                                o_busy
);
    import ttag_pkg::*;

    localparam int FirstStep = (NUM_AXES > 1) ? NUM_AXES - 2 : 0;

    logic [NUM_DIMS_W-1:0] r_num_dims;
    logic [DIM_WIDTH-1:0]  r_dim_size [NUM_AXES];
    logic [ORDER_W-1:0]    r_axis_order;
    logic [ADDR_WIDTH-1:0] r_stride [NUM_AXES];
    logic                  r_busy;
    logic [AXIS_SEL_W-1:0] r_step;

    logic [NUM_DIMS_W-1:0] w_n_act;
    logic [DIM_WIDTH-1:0]  w_ext [NUM_AXES];
    logic [DIM_WIDTH-1:0]  w_oext [NUM_AXES];
    logic [ADDR_WIDTH-1:0] w_prod;
    logic [NUM_DIMS_W-1:0] w_dim_sel;

    always_comb begin
        w_n_act = r_num_dims;
        if (r_num_dims == '0) w_n_act = NUM_DIMS_W'(1);
        if (int'(w_n_act) > NUM_AXES) w_n_act = NUM_DIMS_W'(NUM_AXES);
    end

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            w_ext[a]    = (r_dim_size[a] == '0) ? DIM_WIDTH'(1) : r_dim_size[a];
            o_ext_m1[a] = (r_dim_size[a] == '0) ? '0 : r_dim_size[a] - 1'b1;
        end
    end

    // Extent of each output axis; unused source axis counts as extent 1
    always_comb begin
        logic [AXIS_SEL_W-1:0] src;
        for (int i = 0; i < NUM_AXES; i++) begin
            src       = r_axis_order[AXIS_SEL_W*i +: AXIS_SEL_W];
            w_oext[i] = DIM_WIDTH'(1);
            if (i < int'(w_n_act) && int'(src) < int'(w_n_act)) begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    if (int'(src) == a) w_oext[i] = w_ext[a];
                end
            end
        end
    end

    // stride[k] = stride[k+1] * extent[k+1], one step per cycle unless a register write restarts the walk
    always_comb begin
        w_prod = '0;
        for (int j = 0; j < NUM_AXES; j++) begin
            if (j == int'(r_step) + 1) w_prod = r_stride[j] * ADDR_WIDTH'(w_oext[j]);
        end
    end

    assign w_dim_sel = i_cfg_index - REG_DIM_SIZE_0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims   <= NUM_DIMS_W'(1);
            r_axis_order <= ORDER_RESET;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_dim_size[a] <= DIM_WIDTH'(1);
                r_stride[a]   <= ADDR_WIDTH'(1);
            end
            r_busy <= 1'b0;
            r_step <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (t_cfg_reg'(i_cfg_index)) inside
                    REG_NUM_DIMS: begin
                        r_num_dims <= i_cfg_data[NUM_DIMS_W-1:0];
                    end
                    REG_DIM_SIZE_0, REG_DIM_SIZE_1, REG_DIM_SIZE_2, REG_DIM_SIZE_3: begin
                        for (int a = 0; a < NUM_AXES; a++) begin
                            if (w_dim_sel == NUM_DIMS_W'(a))
                                r_dim_size[a] <= i_cfg_data[DIM_WIDTH-1:0];
                        end
                    end
                    REG_AXIS_ORDER: begin
                        r_axis_order <= i_cfg_data[ORDER_W-1:0];
                    end
                    default: begin
                    end
                endcase
                r_busy <= (NUM_AXES > 1);
                r_step <= AXIS_SEL_W'(FirstStep);
            end else if (r_busy) begin
                for (int k = 0; k < NUM_AXES; k++) begin
                    if (k == int'(r_step)) r_stride[k] <= w_prod;
                end
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    assign o_geom.n_act      = w_n_act;
    assign o_geom.axis_order = r_axis_order;
    assign o_stride          = r_stride;
    assign o_busy            = r_busy;

endmodule

@@ hw/rtl/ttag_front.sv @@
// Front end: input handshake, coordinate odometer and last-element detection.
`timescale 1ns / 1ps

module ttag_front #(
    parameter int NUM_AXES  = 4,
    parameter int DIM_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [ttag_pkg::VALUE_W-1:0]    i_in_value,
    input  ttag_pkg::t_geom                 i_geom,
    input  logic [DIM_WIDTH-1:0]            i_ext_m1 [NUM_AXES],
    input  logic                            i_hold,
    input  logic                            i_q_ready,
    output logic                            o_q_valid,
    output logic [DIM_WIDTH-1:0]            o_crd [NUM_AXES],
    output logic [ttag_pkg::VALUE_W-1:0]    o_value,
    output logic                            o_last
);
    import ttag_pkg::*;

    logic [DIM_WIDTH-1:0] r_coord [NUM_AXES];
    logic [DIM_WIDTH-1:0] n_coord [NUM_AXES];
    logic [NUM_AXES-1:0]  w_end;
    logic                 w_at_end;
    logic                 w_take;

    assign o_in_ready = !i_hold && i_q_ready;
    assign w_take     = i_in_valid && o_in_ready;

    // A counter at or past its last index (extent minus one), or on an unused axis, counts as at its end
    always_comb begin
        w_at_end = 1'b1;
        for (int a = 0; a < NUM_AXES; a++) begin
            w_end[a] = (a >= int'(i_geom.n_act)) || (r_coord[a] >= i_ext_m1[a]);
            w_at_end = w_at_end & w_end[a];
        end
    end

    // Ripple the carry from the innermost active axis outward
    always_comb begin
        logic carry;
        carry = 1'b1;
        for (int a = NUM_AXES - 1; a >= 0; a--) begin
            if (a >= int'(i_geom.n_act) || w_at_end) begin
                n_coord[a] = '0;
            end else if (carry) begin
                n_coord[a] = w_end[a] ? '0 : r_coord[a] + 1'b1;
            end else begin
                n_coord[a] = r_coord[a];
            end
            carry = carry & w_end[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_AXES; a++) r_coord[a] <= '0;
        end else if (w_take) begin
            r_coord <= n_coord;
        end
    end

    // Coordinate of each output axis, taken from its source input axis
    always_comb begin
        logic [AXIS_SEL_W-1:0] src;
        for (int i = 0; i < NUM_AXES; i++) begin
            src      = i_geom.axis_order[AXIS_SEL_W*i +: AXIS_SEL_W];
            o_crd[i] = '0;
            if (i < int'(i_geom.n_act) && int'(src) < int'(i_geom.n_act)) begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    if (int'(src) == a) o_crd[i] = r_coord[a];
                end
            end
        end
    end

    assign o_q_valid = w_take;
    assign o_value   = i_in_value;
    assign o_last    = w_at_end;

endmodule

@@ hw/rtl/ttag_fifo.sv @@
// Short register queue between the front end and the address back end.
`timescale 1ns / 1ps

module ttag_fifo #(
    parameter int WIDTH = 98
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);
    import ttag_pkg::*;

    localparam int PtrW = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0]  r_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr;
    logic [PtrW:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_ready = (r_count != (PtrW+1)'(QUEUE_DEPTH));

endmodule

@@ hw/rtl/ttag_back.sv @@
// Back end: per-axis coordinate-by-stride products, then the address sum.
`timescale 1ns / 1ps

module ttag_back #(
    parameter int NUM_AXES   = 4,
    parameter int DIM_WIDTH  = 16,
    parameter int ADDR_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [DIM_WIDTH-1:0]            i_crd [NUM_AXES],
    input  logic [ttag_pkg::VALUE_W-1:0]    i_value,
    input  logic                            i_last,
    input  logic [ADDR_WIDTH-1:0]           i_stride [NUM_AXES],
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [ADDR_WIDTH-1:0]           o_out_index,
    output logic [ttag_pkg::VALUE_W-1:0]    o_out_value,
    output logic                            o_last
);
    import ttag_pkg::*;

    logic                  r_a_valid;
    logic [ADDR_WIDTH-1:0] r_prod [NUM_AXES];
    logic [VALUE_W-1:0]    r_a_value;
    logic                  r_a_last;

    logic                  r_out_valid;
    logic [ADDR_WIDTH-1:0] r_index;
    logic [VALUE_W-1:0]    r_value;
    logic                  r_last;

    logic                  w_out_ok;
    logic                  w_a_ok;
    logic [ADDR_WIDTH-1:0] w_sum;

    assign w_out_ok = !r_out_valid || i_out_ready;
    assign w_a_ok   = !r_a_valid || w_out_ok;
    assign o_ready  = w_a_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_a_ok)   r_a_valid   <= i_valid;
            if (w_out_ok) r_out_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_ok && i_valid) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_prod[i] <= ADDR_WIDTH'(i_crd[i]) * i_stride[i];
            end
            r_a_value <= i_value;
            r_a_last  <= i_last;
        end
    end

    // address wraps at the address width
    always_comb begin
        w_sum = '0;
        for (int i = 0; i < NUM_AXES; i++) w_sum = w_sum + r_prod[i];
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ok && r_a_valid) begin
            r_index <= w_sum;
            r_value <= r_a_value;
            r_last  <= r_a_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_index = r_index;
    assign o_out_value = r_value;
    assign o_last      = r_last;

endmodule

@@ hw/rtl/tensor_transpose_address_generator.sv @@
// Streams row-major tensor elements through unchanged and tags each one with its
// address in the axis-permuted output tensor, flagging the final element. The
// block takes one element per cycle while the queue has room and no register
// write or stride update holds it off, and returns it through the queue, the
// product stage and the output register; a four-entry queue lets the input keep
// running for a while when the output stalls. After any register write the input
// is held off while one shared multiplier walks the output strides from the
// innermost axis outward. Coordinates restart at zero after the last element and
// after reset; register writes leave them alone.
`timescale 1ns / 1ps

module tensor_transpose_address_generator #(
    parameter int MAX_DIMS   = 4,
    parameter int DIM_WIDTH  = 16,
    parameter int ADDR_WIDTH = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_wr_en,
    input  logic [ttag_pkg::CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [((DIM_WIDTH > ttag_pkg::ORDER_W) ? DIM_WIDTH
                   : ttag_pkg::ORDER_W)-1:0]         i_cfg_data,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic [ttag_pkg::VALUE_W-1:0]            i_in_value,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic [ADDR_WIDTH-1:0]                   o_out_index,
    output logic [ttag_pkg::VALUE_W-1:0]            o_out_value,
    output logic                                    o_last
);
    import ttag_pkg::*;

    localparam int NumAxes  = (MAX_DIMS < MAX_AXES) ? MAX_DIMS : MAX_AXES;
    localparam int CfgWidth = (DIM_WIDTH > ORDER_W) ? DIM_WIDTH : ORDER_W;
    localparam int QueueW   = NumAxes * DIM_WIDTH + VALUE_W + 1;

    t_geom                 w_geom;
    logic [DIM_WIDTH-1:0]  w_ext_m1 [NumAxes];
    logic [ADDR_WIDTH-1:0] w_stride [NumAxes];
    logic                  w_busy;
    logic                  w_hold;

    logic                  w_q_push;
    logic                  w_q_ready;
    logic [DIM_WIDTH-1:0]  w_f_crd [NumAxes];
    logic [VALUE_W-1:0]    w_f_value;
    logic                  w_f_last;
    logic [QueueW-1:0]     w_q_wdata;

    logic                  w_q_valid;
    logic                  w_b_ready;
    logic [QueueW-1:0]     w_q_rdata;
    logic [DIM_WIDTH-1:0]  w_b_crd [NumAxes];

    ttag_cfg #(
        .NUM_AXES   (NumAxes),
        .DIM_WIDTH  (DIM_WIDTH),
        .ADDR_WIDTH (ADDR_WIDTH),
        .CFG_WIDTH  (CfgWidth)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_geom      (w_geom),
        .o_ext_m1    (w_ext_m1),
        .o_stride    (w_stride),
        .o_busy      (w_busy)
    );

    // no transfer while a register is written or strides are being recomputed
    assign w_hold = w_busy || i_cfg_wr_en;

    ttag_front #(
        .NUM_AXES  (NumAxes),
        .DIM_WIDTH (DIM_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_value (i_in_value),
        .i_geom     (w_geom),
        .i_ext_m1   (w_ext_m1),
        .i_hold     (w_hold),
        .i_q_ready  (w_q_ready),
        .o_q_valid  (w_q_push),
        .o_crd      (w_f_crd),
        .o_value    (w_f_value),
        .o_last     (w_f_last)
    );

    // queue word: {coords, value, last}
    always_comb begin
        w_q_wdata[0]           = w_f_last;
        w_q_wdata[VALUE_W:1]   = w_f_value;
        for (int i = 0; i < NumAxes; i++) begin
            w_q_wdata[VALUE_W + 1 + i*DIM_WIDTH +: DIM_WIDTH] = w_f_crd[i];
        end
    end

    ttag_fifo #(
        .WIDTH (QueueW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .o_ready (w_q_ready),
        .i_data  (w_q_wdata),
        .o_valid (w_q_valid),
        .i_pop   (w_q_valid && w_b_ready),
        .o_data  (w_q_rdata)
    );

    always_comb begin
        for (int i = 0; i < NumAxes; i++) begin
            w_b_crd[i] = w_q_rdata[VALUE_W + 1 + i*DIM_WIDTH +: DIM_WIDTH];
        end
    end

    ttag_back #(
        .NUM_AXES   (NumAxes),
        .DIM_WIDTH  (DIM_WIDTH),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .o_ready     (w_b_ready),
        .i_crd       (w_b_crd),
        .i_value     (w_q_rdata[VALUE_W:1]),
        .i_last      (w_q_rdata[0]),
        .i_stride    (w_stride),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_index (o_out_index),
        .o_out_value (o_out_value),
        .o_last      (o_last)
    );

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the tensor transpose address generator.
`timescale 1ns / 1ps

module tb_top;
    import ttag_pkg::*;

    localparam int DIM_W      = 16;
    localparam int ADDR_W     = 32;
    localparam int CFG_DATA_W = (DIM_W > ORDER_W) ? DIM_W : ORDER_W;
    localparam int ITEM_GOAL  = 550;
    localparam int IDLE_PCT   = 32;
    localparam int CYCLE_CAP  = 200000;
    // no idling on a side while its transfer count lies in [STEADY_LO, STEADY_HI)
    localparam int STEADY_LO  = 250;
    localparam int STEADY_HI  = 350;

    typedef struct packed {
        logic [ADDR_W-1:0]  index;
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_elem_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = REG_NUM_DIMS;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic [VALUE_W-1:0]     i_in_value = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [ADDR_W-1:0]      o_out_index;
    logic [VALUE_W-1:0]     o_out_value;
    logic                   o_last;

    tensor_transpose_address_generator #(
        .MAX_DIMS   (MAX_AXES),
        .DIM_WIDTH  (DIM_W),
        .ADDR_WIDTH (ADDR_W)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_value  (i_in_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_index (o_out_index),
        .o_out_value (o_out_value),
        .o_last      (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow of the block's registers and odometer
    logic [NUM_DIMS_W-1:0] shd_num_dims = 3'd1;
    logic [DIM_W-1:0]      shd_dim_size [MAX_AXES] = '{default: 16'd1};
    logic [ORDER_W-1:0]    shd_axis_order = ORDER_RESET;
    logic [DIM_W-1:0]      coord [MAX_AXES] = '{default: '0};

    logic [VALUE_W-1:0] element_queue [$];
    t_elem_result       expected_elems [$];
    int                 items_queued = 0;
    int                 in_sent = 0;
    int                 out_seen = 0;
    int                 error_count = 0;
    int                 cycle_count = 0;

    function automatic int active_axes();
        int n;
        n = int'(shd_num_dims);
        if (n == 0) n = 1;
        if (n > MAX_AXES) n = MAX_AXES;
        return n;
    endfunction

    function automatic logic [ADDR_W-1:0] axis_extent(int a);
        return (shd_dim_size[a] == '0) ? ADDR_W'(1) : ADDR_W'(shd_dim_size[a]);
    endfunction

    // address and last flag for the current element, then advance the odometer
    function automatic t_elem_result permute_address_step(logic [VALUE_W-1:0] value);
        t_elem_result      r;
        int                n, i, a, src;
        logic [ADDR_W-1:0] addr, stride, ext, crd;
        logic              at_end, carried;
        n = active_axes();
        addr = '0;
        stride = ADDR_W'(1);
        for (i = n - 1; i >= 0; i--) begin
            src = int'(shd_axis_order[AXIS_SEL_W*i +: AXIS_SEL_W]);
            ext = ADDR_W'(1);
            crd = '0;
            if (src < n) begin
                ext = axis_extent(src);
                crd = ADDR_W'(coord[src]);
            end
            addr = addr + crd * stride;
            stride = stride * ext;
        end
        at_end = 1'b1;
        for (a = 0; a < n; a++)
            if (ADDR_W'(coord[a]) < axis_extent(a) - 1) at_end = 1'b0;
        r.index = addr;
        r.value = value;
        r.last  = at_end;
        for (a = n; a < MAX_AXES; a++) coord[a] = '0;
        if (at_end) begin
            for (a = 0; a < n; a++) coord[a] = '0;
        end else begin
            carried = 1'b1;
            for (i = n - 1; i >= 0 && carried; i--) begin
                if (ADDR_W'(coord[i]) >= axis_extent(i) - 1) begin
                    coord[i] = '0;
                end else begin
                    coord[i] = coord[i] + 1'b1;
                    carried = 1'b0;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (error_count < 40)
            $display("mismatch at result %0d: %s got %h expected %h",
                     out_seen, what, got, want);
        error_count++;
    endtask

    // input driver
    always @(posedge i_clk) begin
        logic next_valid;
        if (i_rst_n) begin
            next_valid = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                expected_elems.push_back(permute_address_step(i_in_value));
                in_sent++;
                next_valid = 1'b0;
            end
            if (!next_valid && element_queue.size() != 0 &&
                ((in_sent >= STEADY_LO && in_sent < STEADY_HI) ||
                 $urandom_range(99) >= IDLE_PCT)) begin
                i_in_value <= element_queue.pop_front();
                next_valid = 1'b1;
            end
            i_in_valid <= next_valid;
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        t_elem_result want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_elems.size() == 0) begin
                    report_mismatch("unexpected transfer, index", o_out_index, '0);
                end else begin
                    want = expected_elems.pop_front();
                    if (o_out_index !== want.index)
                        report_mismatch("out_index", o_out_index, want.index);
                    if (o_out_value !== want.value)
                        report_mismatch("out_value", o_out_value, want.value);
                    if (o_last !== want.last)
                        report_mismatch("last", 32'(o_last), 32'(want.last));
                end
                out_seen++;
            end
            i_out_ready <= (out_seen >= STEADY_LO && out_seen < STEADY_HI) ||
                           ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // every queued element has come back out
    task automatic wait_idle();
        do @(posedge i_clk);
        while (element_queue.size() != 0 || i_in_valid || out_seen < items_queued);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            REG_NUM_DIMS:   shd_num_dims = data[NUM_DIMS_W-1:0];
            REG_DIM_SIZE_0: shd_dim_size[0] = data[DIM_W-1:0];
            REG_DIM_SIZE_1: shd_dim_size[1] = data[DIM_W-1:0];
            REG_DIM_SIZE_2: shd_dim_size[2] = data[DIM_W-1:0];
            REG_DIM_SIZE_3: shd_dim_size[3] = data[DIM_W-1:0];
            REG_AXIS_ORDER: shd_axis_order = data[ORDER_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic push_element(logic [VALUE_W-1:0] v);
        element_queue.push_back(v);
        items_queued++;
    endtask

    task automatic push_random(int count);
        int k, r;
        for (k = 0; k < count; k++) begin
            r = $urandom_range(99);
            push_element(r < 4 ? 32'h0 : (r < 8 ? 32'hFFFF_FFFF : $urandom));
        end
    endtask

    task automatic random_phase();
        int                 r, n, nd, a, j, tmp, elems, count;
        int                 perm [MAX_AXES];
        logic [DIM_W-1:0]   sz;
        logic [ORDER_W-1:0] order;
        wait_idle();
        r = $urandom_range(99);
        n = (r < 5) ? 0 : ((r < 10) ? $urandom_range(5, 7) : $urandom_range(1, 4));
        nd = (n == 0) ? 1 : ((n > MAX_AXES) ? MAX_AXES : n);
        if ($urandom_range(99) < 85) write_reg(REG_NUM_DIMS, CFG_DATA_W'(n));
        for (a = 0; a < MAX_AXES; a++) begin
            r = $urandom_range(99);
            sz = (r < 5) ? 16'd0 : ((r < 9) ? DIM_W'($urandom_range(6, 65535))
                                            : DIM_W'($urandom_range(1, 5)));
            if ($urandom_range(99) < 85) write_reg(t_cfg_reg'(REG_DIM_SIZE_0 + a), sz);
        end
        if ($urandom_range(99) < 80) begin
            for (a = 0; a < MAX_AXES; a++) perm[a] = a;
            for (a = nd - 1; a > 0; a--) begin
                j = $urandom_range(0, a);
                tmp = perm[a];
                perm[a] = perm[j];
                perm[j] = tmp;
            end
            for (a = 0; a < MAX_AXES; a++)
                order[AXIS_SEL_W*a +: AXIS_SEL_W] = AXIS_SEL_W'(perm[a]);
        end else begin
            order = ORDER_W'($urandom_range(0, 255));
        end
        if ($urandom_range(99) < 90) write_reg(REG_AXIS_ORDER, CFG_DATA_W'(order));
        end_writes();
        // mostly one or two whole tensors when they are short, otherwise a partial run
        elems = 1;
        for (a = 0; a < active_axes(); a++)
            if (elems <= 64) elems = elems * int'(axis_extent(a));
        if (elems <= 64 && $urandom_range(99) < 75)
            count = elems * int'($urandom_range(1, 2));
        else
            count = int'($urandom_range(1, 30));
        push_random(count);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: one element per tensor
        push_element(32'h0);
        push_element(32'hFFFF_FFFF);

        // largest extents, reversed axes: addresses wrap
        wait_idle();
        write_reg(REG_NUM_DIMS, CFG_DATA_W'(4));
        write_reg(REG_DIM_SIZE_0, 16'hFFFF);
        write_reg(REG_DIM_SIZE_1, 16'hFFFF);
        write_reg(REG_DIM_SIZE_2, 16'hFFFF);
        write_reg(REG_DIM_SIZE_3, 16'hFFFF);
        write_reg(REG_AXIS_ORDER, CFG_DATA_W'(8'h1B));
        end_writes();
        push_element(32'hAAAA_AAAA);
        push_element(32'h5555_5555);
        push_random(3);

        // zero axis count, stale counter on a now unused axis
        wait_idle();
        write_reg(REG_NUM_DIMS, CFG_DATA_W'(0));
        write_reg(REG_DIM_SIZE_0, 16'd3);
        end_writes();
        push_random(3);

        // axis count above range, zero extent, repeated source axis
        wait_idle();
        write_reg(REG_NUM_DIMS, CFG_DATA_W'(7));
        write_reg(REG_DIM_SIZE_0, 16'd2);
        write_reg(REG_DIM_SIZE_1, 16'd0);
        write_reg(REG_DIM_SIZE_2, 16'd3);
        write_reg(REG_DIM_SIZE_3, 16'd2);
        write_reg(REG_AXIS_ORDER, CFG_DATA_W'(8'h00));
        end_writes();
        push_random(5);

        // source axis not in use, counters left beyond the new extents
        wait_idle();
        write_reg(REG_NUM_DIMS, CFG_DATA_W'(2));
        write_reg(REG_DIM_SIZE_0, 16'd1);
        write_reg(REG_DIM_SIZE_1, 16'd1);
        write_reg(REG_AXIS_ORDER, CFG_DATA_W'(8'hE3));
        end_writes();
        push_random(3);

        // plain 2-D transpose
        wait_idle();
        write_reg(REG_DIM_SIZE_0, 16'd3);
        write_reg(REG_DIM_SIZE_1, 16'd2);
        write_reg(REG_AXIS_ORDER, CFG_DATA_W'(8'hE1));
        end_writes();
        push_random(7);

        while (items_queued < ITEM_GOAL) random_phase();

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (error_count == 0 && expected_elems.size() == 0 && out_seen == items_queued)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
